// ===== rtl/imhq_pkg.sv =====
// Package of shared types, constants and command codes for the indexed min-heap queue.
package imhq_pkg;

    localparam int MAX_IDS_DEF  = 1024;
    localparam int KEY_BITS_DEF = 32;
    localparam int ID_W         = 10;
    localparam int KEY_W        = 32;
    localparam int CFG_W        = 11;

    localparam logic [1:0] CMD_DECREASE = 2'd0;
    localparam logic [1:0] CMD_EXTRACT  = 2'd1;
    localparam logic [1:0] CMD_PEEK     = 2'd2;
    localparam logic [1:0] CMD_CONTAINS = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_ABSENT   = 2'd2;
    localparam logic [1:0] ST_NOTLOWER = 2'd3;

    typedef struct packed {
        logic [1:0]      cmd;
        logic [ID_W-1:0] item_id;
        logic [KEY_W-1:0] new_key;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [ID_W-1:0]  out_id;
        logic [KEY_W-1:0] out_key;
        logic             in_queue;
    } out_beat_t;

endpackage

// ===== rtl/indexed_min_heap_queue.sv =====
// Top level of the indexed min-heap queue: command sequencer around the heap and position memories.
// Usage: commands arrive as beats on in_valid/in_stall/in_data and each gives exactly one result
// beat on out_valid/out_stall/out_data. Items are handled one at a time. Contains, empty extracts
// and commands on absent ids reach S_DONE straight from S_POS or S_XROOT, peek and refused
// decreases by way of S_KEY as well. Decrease-key passes S_UPRD and S_UPCMP for each heap level
// climbed by the sift; an extract-min that leaves items behind passes S_XLAST once, then S_DNL,
// S_DNR and S_DNCMP for each level descended. The states per level are set by the single read
// port of the heap memory, which is read once per parent or child visited.
// A write of ids_in_use on cfg_we/cfg_wdata, or reset, refills the queue: a clearing pass writes
// every heap slot and position entry, one per cycle, with in_stall high until the pass is done.
// While a result waits under out_stall the next beat is taken and worked on; its result is
// held until the output register is free.
module indexed_min_heap_queue #(
    parameter int MAX_IDS  = imhq_pkg::MAX_IDS_DEF,
    parameter int KEY_BITS = imhq_pkg::KEY_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  imhq_pkg::in_beat_t    in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output imhq_pkg::out_beat_t   out_data,
    input  logic                  cfg_we,
    input  logic [imhq_pkg::CFG_W-1:0] cfg_wdata
);

    localparam int AW = $clog2(MAX_IDS);
    localparam int PW = AW + 1;
    localparam int KW = KEY_BITS;
    localparam int IW = imhq_pkg::ID_W;
    localparam logic [KW-1:0] INF = {KW{1'b1}};
    localparam logic [PW-1:0] MAXP = PW'(MAX_IDS);

    localparam logic [3:0] S_FILL  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_POS   = 4'd2;
    localparam logic [3:0] S_KEY   = 4'd3;
    localparam logic [3:0] S_UPRD  = 4'd4;
    localparam logic [3:0] S_UPCMP = 4'd5;
    localparam logic [3:0] S_XROOT = 4'd6;
    localparam logic [3:0] S_XLAST = 4'd7;
    localparam logic [3:0] S_DNL   = 4'd8;
    localparam logic [3:0] S_DNR   = 4'd9;
    localparam logic [3:0] S_DNCMP = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;

    logic [3:0]      state_reg, state_next;
    logic [PW-1:0]   fill_reg, fill_next;
    logic [PW-1:0]   use_reg, use_next;
    logic [PW-1:0]   cnt_reg, cnt_next;
    logic [1:0]      cmd_reg, cmd_next;
    logic [IW-1:0]   id_reg, id_next;
    logic [KW-1:0]   nkey_reg, nkey_next;
    logic [PW-1:0]   pos_reg, pos_next;
    logic [KW-1:0]   ckey_reg, ckey_next;
    logic [IW-1:0]   cid_reg, cid_next;
    logic [KW-1:0]   lkey_reg, lkey_next;
    logic [IW-1:0]   lid_reg, lid_next;
    logic [PW-1:0]   tpos_reg, tpos_next;
    logic            ovalid_reg, ovalid_next;
    imhq_pkg::out_beat_t obeat_reg, obeat_next;
    imhq_pkg::out_beat_t res_reg, res_next;

    logic [AW-1:0] h_raddr, h_waddr, p_raddr, p_waddr;
    logic [KW-1:0] h_rkey, h_wkey;
    logic [IW-1:0] h_rid, h_wid;
    logic          h_we, p_we;
    logic [PW-1:0] p_rdata, p_wdata;
    logic [PW-1:0] cfg_sat;
    logic          id_ok;
    logic [KW-1:0] key_trim;
    logic [PW-1:0] lpos, rpos;

    imhq_heap_ram #(.AW(AW), .KW(KW), .IW(IW)) u_heap (
        .clk(clk), .raddr(h_raddr), .rkey(h_rkey), .rid(h_rid),
        .we(h_we), .waddr(h_waddr), .wkey(h_wkey), .wid(h_wid)
    );

    imhq_pos_ram #(.AW(AW), .PW(PW)) u_pos (
        .clk(clk), .raddr(p_raddr), .rdata(p_rdata),
        .we(p_we), .waddr(p_waddr), .wdata(p_wdata)
    );

    assign cfg_sat = ({1'b0, cfg_wdata} > {{(PW > 12 ? PW-12 : 0){1'b0}}, 12'(MAX_IDS)}) ? MAXP
                   : PW'(cfg_wdata);
    assign id_ok    = {{(PW-IW > 0 ? PW-IW : 0){1'b0}}, id_reg} < use_reg;
    assign key_trim = KW'(in_data.new_key);
    assign lpos     = PW'({pos_reg, 1'b0});
    assign rpos     = PW'({pos_reg, 1'b1});
    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = ovalid_reg;
    assign out_data  = obeat_reg;

    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        use_next    = use_reg;
        cnt_next    = cnt_reg;
        cmd_next    = cmd_reg;
        id_next     = id_reg;
        nkey_next   = nkey_reg;
        pos_next    = pos_reg;
        ckey_next   = ckey_reg;
        cid_next    = cid_reg;
        lkey_next   = lkey_reg;
        lid_next    = lid_reg;
        tpos_next   = tpos_reg;
        res_next    = res_reg;
        ovalid_next = ovalid_reg && out_stall;
        obeat_next  = obeat_reg;
        h_raddr = '0;
        h_waddr = '0;
        h_wkey  = '0;
        h_wid   = '0;
        h_we    = 1'b0;
        p_raddr = id_reg[AW-1:0];
        p_waddr = '0;
        p_wdata = '0;
        p_we    = 1'b0;

        case (state_reg)
            S_FILL:
            begin
                h_we    = 1'b1;
                h_waddr = fill_reg[AW-1:0];
                h_wkey  = INF;
                h_wid   = IW'(fill_reg);
                p_we    = 1'b1;
                p_waddr = fill_reg[AW-1:0];
                p_wdata = (fill_reg < use_reg) ? fill_reg + 1'b1 : '0;
                fill_next = fill_reg + 1'b1;
                if (fill_reg == MAXP - 1'b1)
                begin
                    state_next = S_IDLE;
                    cnt_next   = use_reg;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next  = in_data.cmd;
                    id_next   = in_data.item_id;
                    nkey_next = key_trim;
                    p_raddr   = in_data.item_id[AW-1:0];
                    h_raddr   = '0;
                    state_next = (in_data.cmd == imhq_pkg::CMD_EXTRACT) ? S_XROOT : S_POS;
                end
            end
            S_POS:
            begin
                pos_next = p_rdata;
                h_raddr  = AW'(p_rdata - 1'b1);
                res_next.out_id  = id_reg;
                res_next.out_key = '0;
                res_next.in_queue = 1'b0;
                res_next.status   = imhq_pkg::ST_OK;
                if (!id_ok)
                begin
                    res_next.status = imhq_pkg::ST_ABSENT;
                    state_next = S_DONE;
                end
                else if (cmd_reg == imhq_pkg::CMD_CONTAINS)
                begin
                    res_next.in_queue = (p_rdata != '0);
                    state_next = S_DONE;
                end
                else if (p_rdata == '0)
                begin
                    res_next.status = imhq_pkg::ST_ABSENT;
                    state_next = S_DONE;
                end
                else
                begin
                    res_next.in_queue = 1'b1;
                    state_next = S_KEY;
                end
            end
            S_KEY:
            begin
                if (cmd_reg == imhq_pkg::CMD_PEEK)
                begin
                    res_next.out_key = 32'(h_rkey);
                    state_next = S_DONE;
                end
                else if (nkey_reg >= h_rkey)
                begin
                    res_next.status = imhq_pkg::ST_NOTLOWER;
                    state_next = S_DONE;
                end
                else
                begin
                    cid_next   = h_rid;
                    state_next = S_UPRD;
                end
            end
            S_UPRD:
            begin
                if (pos_reg == PW'(1))
                begin
                    h_we    = 1'b1;
                    h_waddr = '0;
                    h_wkey  = nkey_reg;
                    h_wid   = cid_reg;
                    p_we    = 1'b1;
                    p_waddr = cid_reg[AW-1:0];
                    p_wdata = pos_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    h_raddr    = AW'((pos_reg >> 1) - 1'b1);
                    state_next = S_UPCMP;
                end
            end
            S_UPCMP:
            begin
                if (h_rkey <= nkey_reg)
                begin
                    h_we    = 1'b1;
                    h_waddr = AW'(pos_reg - 1'b1);
                    h_wkey  = nkey_reg;
                    h_wid   = cid_reg;
                    p_we    = 1'b1;
                    p_waddr = cid_reg[AW-1:0];
                    p_wdata = pos_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    h_we    = 1'b1;
                    h_waddr = AW'(pos_reg - 1'b1);
                    h_wkey  = h_rkey;
                    h_wid   = h_rid;
                    p_we    = 1'b1;
                    p_waddr = h_rid[AW-1:0];
                    p_wdata = pos_reg;
                    pos_next   = pos_reg >> 1;
                    state_next = S_UPRD;
                end
            end
            S_XROOT:
            begin
                res_next.out_id   = id_reg;
                res_next.out_key  = '0;
                res_next.in_queue = 1'b0;
                res_next.status   = imhq_pkg::ST_OK;
                if (cnt_reg == '0)
                begin
                    res_next.status = imhq_pkg::ST_EMPTY;
                    state_next = S_DONE;
                end
                else
                begin
                    res_next.out_id  = h_rid;
                    res_next.out_key = 32'(h_rkey);
                    p_we    = 1'b1;
                    p_waddr = h_rid[AW-1:0];
                    p_wdata = '0;
                    h_raddr = AW'(cnt_reg - 1'b1);
                    cnt_next = cnt_reg - 1'b1;
                    state_next = (cnt_reg == PW'(1)) ? S_DONE : S_XLAST;
                end
            end
            S_XLAST:
            begin
                cid_next   = h_rid;
                ckey_next  = h_rkey;
                pos_next   = PW'(1);
                h_raddr    = AW'(1);
                state_next = S_DNL;
            end
            S_DNL:
            begin
                lkey_next = h_rkey;
                lid_next  = h_rid;
                h_raddr   = AW'(rpos - 1'b1);
                state_next = S_DNR;
            end
            S_DNR:
            begin
                tpos_next = pos_reg;
                if (lpos <= cnt_reg && lkey_reg < ckey_reg)
                begin
                    tpos_next = lpos;
                end
                if (rpos <= cnt_reg && h_rkey <
                    ((lpos <= cnt_reg && lkey_reg < ckey_reg) ? lkey_reg : ckey_reg))
                begin
                    tpos_next = rpos;
                    lkey_next = h_rkey;
                    lid_next  = h_rid;
                end
                state_next = S_DNCMP;
            end
            S_DNCMP:
            begin
                h_we = 1'b1;
                p_we = 1'b1;
                h_waddr = AW'(pos_reg - 1'b1);
                if (tpos_reg == pos_reg)
                begin
                    h_wkey  = ckey_reg;
                    h_wid   = cid_reg;
                    p_waddr = cid_reg[AW-1:0];
                    p_wdata = pos_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    h_wkey  = lkey_reg;
                    h_wid   = lid_reg;
                    p_waddr = lid_reg[AW-1:0];
                    p_wdata = pos_reg;
                    pos_next = tpos_reg;
                    h_raddr  = AW'({tpos_reg, 1'b0} - 1'b1);
                    state_next = S_DNL;
                end
            end
            S_DONE:
            begin
                if (!ovalid_reg || !out_stall)
                begin
                    ovalid_next = 1'b1;
                    obeat_next  = res_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            use_next   = cfg_sat;
            fill_next  = '0;
            state_next = S_FILL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_FILL;
            fill_reg   <= '0;
            use_reg    <= MAXP;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            use_reg    <= use_next;
            cnt_reg    <= cnt_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        id_reg    <= id_next;
        nkey_reg  <= nkey_next;
        pos_reg   <= pos_next;
        ckey_reg  <= ckey_next;
        cid_reg   <= cid_next;
        lkey_reg  <= lkey_next;
        lid_reg   <= lid_next;
        tpos_reg  <= tpos_next;
        res_reg   <= res_next;
        obeat_reg <= obeat_next;
    end

endmodule

// ===== rtl/imhq_heap_ram.sv =====
// Heap store: key and id per heap slot, one synchronous read and one write port.
module imhq_heap_ram #(
    parameter int AW = 10,
    parameter int KW = 32,
    parameter int IW = 10
) (
    input  logic          clk,
    input  logic [AW-1:0] raddr,
    output logic [KW-1:0] rkey,
    output logic [IW-1:0] rid,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [KW-1:0] wkey,
    input  logic [IW-1:0] wid
);

    logic [KW+IW-1:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= {wkey, wid};
        end
        {rkey, rid} <= mem[raddr];
    end

endmodule

// ===== rtl/imhq_pos_ram.sv =====
// Position map: heap position of each id, one synchronous read and one write port.
module imhq_pos_ram #(
    parameter int AW = 10,
    parameter int PW = 11
) (
    input  logic          clk,
    input  logic [AW-1:0] raddr,
    output logic [PW-1:0] rdata,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [PW-1:0] wdata
);

    logic [PW-1:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/imhq_checker.sv =====
// Port checker for the indexed min-heap queue, bound to the top level.
module imhq_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input imhq_pkg::out_beat_t out_data,
    input logic                cfg_we
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result beat changed");

    a_cfg_stall: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> in_stall)
        else $error("input taken during refill");

    a_ok_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == imhq_pkg::ST_EMPTY |-> out_data.out_key == '0
        && !out_data.in_queue)
        else $error("empty extract carried data");

    a_absent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == imhq_pkg::ST_ABSENT |-> !out_data.in_queue)
        else $error("absent id reported present");

    a_accept_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second beat taken before result");

endmodule

bind indexed_min_heap_queue imhq_checker u_imhq_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data), .cfg_we(cfg_we)
);

// ===== dv/tb_indexed_min_heap_queue.sv =====
// Self-checking testbench for the indexed min-heap queue, with its own heap predictor.
`timescale 1ns / 1ps

module tb_indexed_min_heap_queue;

    localparam int N_SLOTS = 1024;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [imhq_pkg::KEY_W-1:0] KEY_INF = '1;

    typedef struct {
        logic                do_cfg;
        int                  cfg_val;
        imhq_pkg::in_beat_t  beat;
        logic                typed;
        imhq_pkg::out_beat_t want;
    } stim_row_t;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    imhq_pkg::in_beat_t  in_data;
    logic      out_valid;
    logic      out_stall;
    imhq_pkg::out_beat_t out_data;
    logic      cfg_we;
    logic [imhq_pkg::CFG_W-1:0] cfg_wdata;

    logic [imhq_pkg::KEY_W-1:0] model_key [N_SLOTS];
    logic [imhq_pkg::ID_W-1:0]  model_id  [N_SLOTS];
    int               model_pos [N_SLOTS];
    int               model_count;
    int               model_ids;

    imhq_pkg::out_beat_t pending_results [$];
    stim_row_t directed_rows [$];
    int        tx_pct;
    int        rx_pct;
    logic      hold_req;
    int        err_count = 0;
    int        idle_cycles;
    int        items_sent;
    int        results_seen = 0;
    int        cfg_writes;

    indexed_min_heap_queue i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic void refill_model(int value);
        model_ids = (value > N_SLOTS) ? N_SLOTS : value;
        for (int i = 0; i < N_SLOTS; i++)
        begin
            model_key[i] = KEY_INF;
            model_id[i]  = i[imhq_pkg::ID_W-1:0];
            model_pos[i] = (i < model_ids) ? i + 1 : 0;
        end
        model_count = model_ids;
    endfunction

    function automatic void swap_slots(int a, int b);
        logic [imhq_pkg::KEY_W-1:0] k;
        logic [imhq_pkg::ID_W-1:0]  d;
        k = model_key[a-1];
        d = model_id[a-1];
        model_key[a-1] = model_key[b-1];
        model_id[a-1]  = model_id[b-1];
        model_key[b-1] = k;
        model_id[b-1]  = d;
        model_pos[model_id[a-1]] = a;
        model_pos[model_id[b-1]] = b;
    endfunction

    function automatic imhq_pkg::out_beat_t heap_predict(imhq_pkg::in_beat_t b);
        imhq_pkg::out_beat_t r;
        int  p;
        int  best;
        int  up;
        logic in_range;
        r = '0;
        r.out_id = b.item_id;
        in_range = (int'(b.item_id) < model_ids);
        p = in_range ? model_pos[b.item_id] : 0;
        if (b.cmd == imhq_pkg::CMD_EXTRACT)
        begin
            if (model_count == 0)
            begin
                r.status = imhq_pkg::ST_EMPTY;
            end
            else
            begin
                r.out_id  = model_id[0];
                r.out_key = model_key[0];
                model_pos[model_id[0]] = 0;
                if (model_count > 1)
                begin
                    model_key[0] = model_key[model_count-1];
                    model_id[0]  = model_id[model_count-1];
                    model_pos[model_id[0]] = 1;
                end
                model_count--;
                p = 1;
                forever
                begin
                    best = p;
                    if (2*p <= model_count && model_key[2*p-1] < model_key[best-1])
                        best = 2*p;
                    if (2*p+1 <= model_count && model_key[2*p] < model_key[best-1])
                        best = 2*p + 1;
                    if (best == p)
                        break;
                    swap_slots(best, p);
                    p = best;
                end
            end
        end
        else if (!in_range)
        begin
            r.status = imhq_pkg::ST_ABSENT;
        end
        else if (b.cmd == imhq_pkg::CMD_CONTAINS)
        begin
            r.in_queue = (p != 0);
        end
        else if (p == 0)
        begin
            r.status = imhq_pkg::ST_ABSENT;
        end
        else if (b.cmd == imhq_pkg::CMD_PEEK)
        begin
            r.out_key  = model_key[p-1];
            r.in_queue = 1'b1;
        end
        else
        begin
            r.in_queue = 1'b1;
            if (b.new_key >= model_key[p-1])
            begin
                r.status = imhq_pkg::ST_NOTLOWER;
            end
            else
            begin
                model_key[p-1] = b.new_key;
                while (p > 1)
                begin
                    up = p / 2;
                    if (model_key[up-1] <= model_key[p-1])
                        break;
                    swap_slots(up, p);
                    p = up;
                end
            end
        end
        return r;
    endfunction

    task automatic write_ids_in_use(int value);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value[imhq_pkg::CFG_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        refill_model(value);
        cfg_writes++;
    endtask

    task automatic send_beat(imhq_pkg::in_beat_t b, logic typed, imhq_pkg::out_beat_t want);
        imhq_pkg::out_beat_t got;
        if ($urandom_range(0, 99) < tx_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < tx_pct);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        do
            @(posedge clk);
        while (in_stall);
        got = heap_predict(b);
        pending_results.push_back(typed ? want : got);
        items_sent++;
    endtask

    function automatic imhq_pkg::in_beat_t random_beat();
        imhq_pkg::in_beat_t b;
        int sel;
        int pos;
        logic [imhq_pkg::KEY_W-1:0] cur;
        b.cmd     = imhq_pkg::CMD_DECREASE;
        b.item_id = (model_ids > 0) ?
                    imhq_pkg::ID_W'($urandom_range(0, model_ids - 1)) : '0;
        b.new_key = $urandom;
        sel = $urandom_range(0, 99);
        if (sel < 42)
        begin
            pos = (int'(b.item_id) < model_ids) ? model_pos[b.item_id] : 0;
            cur = (pos != 0) ? model_key[pos-1] : KEY_INF;
            if ($urandom_range(0, 3) == 0)
                b.new_key = $urandom_range(0, 15);
            else if (cur != 0)
                b.new_key = $urandom_range(0, cur - 1);
        end
        else if (sel < 67)
            b.cmd = imhq_pkg::CMD_EXTRACT;
        else if (sel < 77)
            b.cmd = imhq_pkg::CMD_PEEK;
        else if (sel < 85)
            b.cmd = imhq_pkg::CMD_CONTAINS;
        else
        begin
            b.cmd     = 2'($urandom_range(0, 3));
            b.item_id = imhq_pkg::ID_W'($urandom);
        end
        return b;
    endfunction

    initial
    begin
        imhq_pkg::in_beat_t  b;
        imhq_pkg::out_beat_t w;
        int        phase_items;
        int        sz;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        tx_pct    = 17;
        rx_pct    = 62;
        hold_req  = 1'b0;
        items_sent = 0;
        cfg_writes = 0;
        refill_model(N_SLOTS);
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        directed_rows.push_back('{0, 0, '{imhq_pkg::CMD_PEEK, 10'd0, 32'd0}, 1,
                                  '{imhq_pkg::ST_OK, 10'd0, KEY_INF, 1'b1}});
        directed_rows.push_back('{0, 0, '{imhq_pkg::CMD_PEEK, 10'd1023, 32'd0}, 1,
                                  '{imhq_pkg::ST_OK, 10'd1023, KEY_INF, 1'b1}});
        directed_rows.push_back('{0, 0, '{imhq_pkg::CMD_CONTAINS, 10'd5, 32'd0}, 1,
                                  '{imhq_pkg::ST_OK, 10'd5, 32'd0, 1'b1}});
        directed_rows.push_back('{0, 0, '{imhq_pkg::CMD_DECREASE, 10'd7, KEY_INF}, 1,
                                  '{imhq_pkg::ST_NOTLOWER, 10'd7, 32'd0, 1'b1}});
        directed_rows.push_back('{0, 0, '{imhq_pkg::CMD_DECREASE, 10'd7, 32'd0}, 1,
                                  '{imhq_pkg::ST_OK, 10'd7, 32'd0, 1'b1}});
        directed_rows.push_back('{0, 0, '{imhq_pkg::CMD_DECREASE, 10'd1023, 32'hFFFF_FFFE},
                                  0, '0});
        directed_rows.push_back('{0, 0, '{imhq_pkg::CMD_DECREASE, 10'd512, 32'd0}, 0, '0});
        directed_rows.push_back('{0, 0, '{imhq_pkg::CMD_EXTRACT, 10'd3, 32'd0}, 1,
                                  '{imhq_pkg::ST_OK, 10'd7, 32'd0, 1'b0}});
        directed_rows.push_back('{0, 0, '{imhq_pkg::CMD_PEEK, 10'd7, 32'd0}, 1,
                                  '{imhq_pkg::ST_ABSENT, 10'd7, 32'd0, 1'b0}});
        directed_rows.push_back('{0, 0, '{imhq_pkg::CMD_DECREASE, 10'd7, 32'd1}, 1,
                                  '{imhq_pkg::ST_ABSENT, 10'd7, 32'd0, 1'b0}});
        directed_rows.push_back('{0, 0, '{imhq_pkg::CMD_CONTAINS, 10'd7, 32'd0}, 1,
                                  '{imhq_pkg::ST_OK, 10'd7, 32'd0, 1'b0}});
        directed_rows.push_back('{0, 0, '{imhq_pkg::CMD_EXTRACT, 10'd0, 32'd0}, 0, '0});
        directed_rows.push_back('{0, 0, '{imhq_pkg::CMD_EXTRACT, 10'd0, 32'd0}, 0, '0});
        directed_rows.push_back('{0, 0, '{imhq_pkg::CMD_PEEK, 10'd1023, 32'd0}, 0, '0});
        directed_rows.push_back('{1, 1, '{imhq_pkg::CMD_CONTAINS, 10'd1, 32'd0}, 1,
                                  '{imhq_pkg::ST_ABSENT, 10'd1, 32'd0, 1'b0}});
        directed_rows.push_back('{0, 0, '{imhq_pkg::CMD_PEEK, 10'd1023, 32'd0}, 1,
                                  '{imhq_pkg::ST_ABSENT, 10'd1023, 32'd0, 1'b0}});
        directed_rows.push_back('{0, 0, '{imhq_pkg::CMD_EXTRACT, 10'd9, 32'd0}, 1,
                                  '{imhq_pkg::ST_OK, 10'd0, KEY_INF, 1'b0}});
        directed_rows.push_back('{0, 0, '{imhq_pkg::CMD_EXTRACT, 10'd9, 32'd0}, 1,
                                  '{imhq_pkg::ST_EMPTY, 10'd9, 32'd0, 1'b0}});
        directed_rows.push_back('{0, 0, '{imhq_pkg::CMD_CONTAINS, 10'd0, 32'd0}, 1,
                                  '{imhq_pkg::ST_OK, 10'd0, 32'd0, 1'b0}});
        directed_rows.push_back('{1, 0, '{imhq_pkg::CMD_EXTRACT, 10'd1023, 32'd0}, 1,
                                  '{imhq_pkg::ST_EMPTY, 10'd1023, 32'd0, 1'b0}});
        directed_rows.push_back('{0, 0, '{imhq_pkg::CMD_PEEK, 10'd0, 32'd0}, 1,
                                  '{imhq_pkg::ST_ABSENT, 10'd0, 32'd0, 1'b0}});
        directed_rows.push_back('{1, 2047, '{imhq_pkg::CMD_PEEK, 10'd1023, 32'd0}, 1,
                                  '{imhq_pkg::ST_OK, 10'd1023, KEY_INF, 1'b1}});
        directed_rows.push_back('{1, 3, '{imhq_pkg::CMD_DECREASE, 10'd2, 32'd5}, 0, '0});
        directed_rows.push_back('{0, 0, '{imhq_pkg::CMD_DECREASE, 10'd1, 32'd5}, 0, '0});
        directed_rows.push_back('{0, 0, '{imhq_pkg::CMD_EXTRACT, 10'd0, 32'd0}, 0, '0});

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].do_cfg)
                write_ids_in_use(directed_rows[i].cfg_val);
            send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);
        end

        for (int phase = 0; phase < 3; phase++)
        begin
            tx_pct = (phase == 0) ? 17 : (phase == 1) ? 62 : 0;
            rx_pct = (phase == 0) ? 62 : (phase == 1) ? 17 : 0;
            phase_items = 0;
            while (phase_items < 480)
            begin
                case ($urandom_range(0, 9))
                    0:       sz = N_SLOTS;
                    1:       sz = $urandom_range(N_SLOTS + 1, 2047);
                    2:       sz = $urandom_range(1, 2);
                    default: sz = $urandom_range(3, 64);
                endcase
                write_ids_in_use(sz);
                if (phase == 2 && phase_items == 0)
                begin
                    hold_req <= 1'b1;
                    @(posedge clk);
                    hold_req <= 1'b0;
                end
                for (int k = 0; k < 80; k++)
                begin
                    b = random_beat();
                    w = '0;
                    send_beat(b, 1'b0, w);
                    phase_items++;
                end
                hold_req <= 1'b0;
            end
        end
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        $display("Covered %0d commands and %0d results over %0d ids_in_use settings,",
                 items_sent, results_seen, cfg_writes + 1);
        $display("with all four commands, errors, ties, refills and a long output hold-off.");
        if (err_count == 0)
            $display("tb_indexed_min_heap_queue: done, clean");
        else
            $display("tb_indexed_min_heap_queue: done, errors");
        $finish;
    end

    initial
    begin
        int hold;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                for (hold = 0; hold < 400; hold++)
                    @(posedge clk);
                while (hold_req)
                    @(posedge clk);
            end
            out_stall <= ($urandom_range(0, 99) < rx_pct);
        end
    end

    always @(posedge clk)
    begin
        imhq_pkg::out_beat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result beat %p", $time, out_data);
                err_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_data.status !== want.status)
                begin
                    $display("%0t: status expected %0d got %0d", $time, want.status,
                             out_data.status);
                    err_count++;
                end
                if (out_data.out_id !== want.out_id)
                begin
                    $display("%0t: out_id expected %0d got %0d", $time, want.out_id,
                             out_data.out_id);
                    err_count++;
                end
                if (out_data.out_key !== want.out_key)
                begin
                    $display("%0t: out_key expected %h got %h", $time, want.out_key,
                             out_data.out_key);
                    err_count++;
                end
                if (out_data.in_queue !== want.in_queue)
                begin
                    $display("%0t: in_queue expected %0d got %0d", $time, want.in_queue,
                             out_data.in_queue);
                    err_count++;
                end
            end
        end
    end

    initial
    begin
        idle_cycles  = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog expired with %0d results outstanding", $time,
                         pending_results.size());
                $display("tb_indexed_min_heap_queue: done, errors");
                $finish;
            end
        end
    end

endmodule
